// ===== rtl/spf_pkg.sv =====
package spf_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_NUMBER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_TYPE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEC_HDR_FLAG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQUENCE_FLAGS = 3'd4;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic       enable;
        logic [2:0] version_number;
        logic       packet_type;
        logic       secondary_header_flag;
        logic [1:0] sequence_flags;
    } t_cfg;

    // one classified item waiting for the back end
    typedef struct packed {
        logic        is_data;
        logic        close;
        logic [10:0] apid;
        logic [7:0]  payload_length;
        logic [31:0] pkt_time;
        logic [7:0]  data_byte;
    } t_cmd;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/space_packet_framer_crc16_unit.sv =====
// Space packet framer with CRC-16/CCITT. A start item emits the 6-byte primary
// header and the 4-byte timestamp secondary header (plus the two CRC bytes at once
// when its payload length is zero); each payload item emits its byte, and the
// last one of a packet also emits the CRC high and low bytes. Input is taken one
// item per clock, while not stalled, into a command queue of 2**QUEUE_DEPTH_LOG2
// entries; the back end drains it at one output byte per clock while the output
// is not stalled. A start yields 10 or 12 output bytes, a payload item 1 or 3,
// and o_stall rises only while the queue is full. Counters on each result
// already include the packet closed by it. Configuration writes are accepted
// in any cycle but must only be made while the block is idle.
module space_packet_framer_crc16_unit
    import spf_pkg::*;
#(
    parameter int QUEUE_DEPTH_LOG2 = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_opcode,
    input  logic [10:0]           i_apid,
    input  logic [7:0]            i_payload_length,
    input  logic [31:0]           i_pkt_time,
    input  logic [7:0]            i_data_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_out_byte,
    output logic                  o_last_of_run,
    output logic                  o_end_of_packet,
    output logic [13:0]           o_sequence_count,
    output logic [31:0]           o_packets_sent_total,
    output logic [31:0]           o_bytes_sent_total,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic fifo_full;
    logic push;
    t_cmd push_cmd;
    logic pop;
    logic head_valid;
    t_cmd head;
    logic accept;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = fifo_full;
    assign accept      = i_valid && !fifo_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable                <= 1'b1;
            r_cfg.version_number        <= 3'd0;
            r_cfg.packet_type           <= 1'b0;
            r_cfg.secondary_header_flag <= 1'b1;
            r_cfg.sequence_flags        <= 2'd3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ENABLE:         r_cfg.enable                <= i_cfg_data[0];
                CFG_VERSION_NUMBER: r_cfg.version_number        <= i_cfg_data[2:0];
                CFG_PACKET_TYPE:    r_cfg.packet_type           <= i_cfg_data[0];
                CFG_SEC_HDR_FLAG:   r_cfg.secondary_header_flag <= i_cfg_data[0];
                CFG_SEQUENCE_FLAGS: r_cfg.sequence_flags        <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    spf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_enable         (r_cfg.enable),
        .i_accept         (accept),
        .i_opcode         (i_opcode),
        .i_apid           (i_apid),
        .i_payload_length (i_payload_length),
        .i_pkt_time       (i_pkt_time),
        .i_data_byte      (i_data_byte),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    spf_cmd_fifo #(
        .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (push_cmd),
        .i_pop        (pop),
        .o_full       (fifo_full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    spf_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (r_cfg),
        .i_head_valid         (head_valid),
        .i_head               (head),
        .o_pop                (pop),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_out_byte           (o_out_byte),
        .o_last_of_run        (o_last_of_run),
        .o_end_of_packet      (o_end_of_packet),
        .o_sequence_count     (o_sequence_count),
        .o_packets_sent_total (o_packets_sent_total),
        .o_bytes_sent_total   (o_bytes_sent_total)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !fifo_full)
        else $error("command pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head_valid)
        else $error("command popped from an empty queue");

    a_eop_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_end_of_packet) |-> o_last_of_run)
        else $error("packet end not marked as last of run");

    a_eop_counts_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_end_of_packet) |=>
            (!o_valid || o_packets_sent_total == $past(o_packets_sent_total)
             || o_packets_sent_total == $past(o_packets_sent_total) + 32'd1))
        else $error("packet total moved by more than one packet");

endmodule

// ===== rtl/spf_front.sv =====
module spf_front
    import spf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_enable,
    input  logic        i_accept,
    input  logic        i_opcode,
    input  logic [10:0] i_apid,
    input  logic [7:0]  i_payload_length,
    input  logic [31:0] i_pkt_time,
    input  logic [7:0]  i_data_byte,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic       r_open;
    logic       n_open;
    logic [7:0] r_remain;
    logic [7:0] n_remain;
    logic [7:0] remain_dec;

    assign remain_dec = r_remain - 8'd1;

    always_comb begin
        n_open   = r_open;
        n_remain = r_remain;
        o_push   = 1'b0;
        o_cmd.is_data        = i_opcode;
        o_cmd.close          = 1'b0;
        o_cmd.apid           = i_apid;
        o_cmd.payload_length = i_payload_length;
        o_cmd.pkt_time       = i_pkt_time;
        o_cmd.data_byte      = i_data_byte;
        if (i_accept && i_enable) begin
            if (i_opcode == OP_START) begin
                // a start abandons whatever was open
                o_push      = 1'b1;
                o_cmd.close = (i_payload_length == 8'd0);
                n_open      = (i_payload_length != 8'd0);
                n_remain    = i_payload_length;
            end else if (r_open) begin
                o_push      = 1'b1;
                o_cmd.close = (remain_dec == 8'd0);
                n_remain    = remain_dec;
                n_open      = (remain_dec != 8'd0);
            end
            // stray payload bytes fall through with no push
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open   <= 1'b0;
            r_remain <= 8'd0;
        end else begin
            r_open   <= n_open;
            r_remain <= n_remain;
        end
    end

endmodule

// ===== rtl/spf_cmd_fifo.sv =====
module spf_cmd_fifo
    import spf_pkg::*;
#(
    parameter int DEPTH_LOG2 = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_head_valid,
    output t_cmd o_head
);

    localparam int DEPTH = 1 << DEPTH_LOG2;

    t_cmd                r_mem [DEPTH];
    logic [DEPTH_LOG2:0] r_wr;
    logic [DEPTH_LOG2:0] r_rd;
    logic [DEPTH_LOG2:0] level;

    assign level        = r_wr - r_rd;
    assign o_full       = (level == (DEPTH_LOG2+1)'(DEPTH));
    assign o_head_valid = (level != '0);
    assign o_head       = r_mem[r_rd[DEPTH_LOG2-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[DEPTH_LOG2-1:0]] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/spf_back.sv =====
module spf_back
    import spf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_head_valid,
    input  t_cmd        i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_end_of_packet,
    output logic [13:0] o_sequence_count,
    output logic [31:0] o_packets_sent_total,
    output logic [31:0] o_bytes_sent_total
);

    // byte positions within one command
    localparam logic [3:0] STEP_PID_HI  = 4'd0;
    localparam logic [3:0] STEP_PID_LO  = 4'd1;
    localparam logic [3:0] STEP_SEQ_HI  = 4'd2;
    localparam logic [3:0] STEP_SEQ_LO  = 4'd3;
    localparam logic [3:0] STEP_LEN_HI  = 4'd4;
    localparam logic [3:0] STEP_LEN_LO  = 4'd5;
    localparam logic [3:0] STEP_TS_3    = 4'd6;
    localparam logic [3:0] STEP_TS_2    = 4'd7;
    localparam logic [3:0] STEP_TS_1    = 4'd8;
    localparam logic [3:0] STEP_TS_0    = 4'd9;
    localparam logic [3:0] STEP_HCRC_HI = 4'd10;
    localparam logic [3:0] STEP_HCRC_LO = 4'd11;
    localparam logic [3:0] STEP_DATA    = 4'd0;
    localparam logic [3:0] STEP_DCRC_HI = 4'd1;
    localparam logic [3:0] STEP_DCRC_LO = 4'd2;

    logic [3:0]  r_step;
    logic [3:0]  n_step;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [13:0] r_seq;
    logic [13:0] n_seq;
    logic [31:0] r_pkts;
    logic [31:0] n_pkts;
    logic [31:0] r_bytes;
    logic [31:0] n_bytes;
    logic [7:0]  r_open_len;
    logic [7:0]  n_open_len;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_eop;
    logic [13:0] r_out_seq;
    logic [31:0] r_out_pkts;
    logic [31:0] r_out_bytes;

    logic        emit;
    logic        crc_hi;
    logic        crc_lo;
    logic        last;
    logic [7:0]  hdr_byte;
    logic [7:0]  sel_byte;
    logic [15:0] crc_base;
    logic [15:0] pid;
    logic [15:0] seq_word;
    logic [15:0] data_len;

    assign emit = i_head_valid && (!r_out_valid || !i_stall);

    assign pid      = {i_cfg.version_number, i_cfg.packet_type,
                       i_cfg.secondary_header_flag, i_head.apid};
    assign seq_word = {i_cfg.sequence_flags, r_seq};
    assign data_len = 16'(i_head.payload_length) + 16'd5;

    always_comb begin
        case (r_step)
            STEP_PID_HI: hdr_byte = pid[15:8];
            STEP_PID_LO: hdr_byte = pid[7:0];
            STEP_SEQ_HI: hdr_byte = seq_word[15:8];
            STEP_SEQ_LO: hdr_byte = seq_word[7:0];
            STEP_LEN_HI: hdr_byte = data_len[15:8];
            STEP_LEN_LO: hdr_byte = data_len[7:0];
            STEP_TS_3:   hdr_byte = i_head.pkt_time[31:24];
            STEP_TS_2:   hdr_byte = i_head.pkt_time[23:16];
            STEP_TS_1:   hdr_byte = i_head.pkt_time[15:8];
            STEP_TS_0:   hdr_byte = i_head.pkt_time[7:0];
            default:     hdr_byte = 8'h00;
        endcase
    end

    always_comb begin
        crc_hi = i_head.is_data ? (r_step == STEP_DCRC_HI) : (r_step == STEP_HCRC_HI);
        crc_lo = i_head.is_data ? (r_step == STEP_DCRC_LO) : (r_step == STEP_HCRC_LO);
        if (crc_lo) begin
            last = 1'b1;
        end else if (i_head.is_data) begin
            last = (r_step == STEP_DATA) && !i_head.close;
        end else begin
            last = (r_step == STEP_TS_0) && !i_head.close;
        end

        if (crc_hi) begin
            sel_byte = r_crc[15:8];
        end else if (crc_lo) begin
            sel_byte = r_crc[7:0];
        end else if (i_head.is_data) begin
            sel_byte = i_head.data_byte;
        end else begin
            sel_byte = hdr_byte;
        end

        // a start restarts the checksum with its first header byte
        crc_base = (!i_head.is_data && r_step == STEP_PID_HI) ? CRC_INIT : r_crc;

        n_step     = r_step;
        n_crc      = r_crc;
        n_seq      = r_seq;
        n_pkts     = r_pkts;
        n_bytes    = r_bytes;
        n_open_len = r_open_len;
        if (emit) begin
            n_step = last ? 4'd0 : r_step + 4'd1;
            if (!i_head.is_data && r_step == STEP_PID_HI) begin
                n_open_len = i_head.payload_length;
            end
            if (crc_lo) begin
                n_crc   = CRC_INIT;
                n_seq   = r_seq + 14'd1;
                n_pkts  = r_pkts + 32'd1;
                n_bytes = r_bytes + 32'd12 + 32'(r_open_len);
            end else if (!crc_hi) begin
                n_crc = crc_byte(crc_base, sel_byte);
            end
        end
    end

    assign o_pop = emit && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= 4'd0;
            r_crc       <= CRC_INIT;
            r_seq       <= 14'd0;
            r_pkts      <= 32'd0;
            r_bytes     <= 32'd0;
            r_open_len  <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_step     <= n_step;
            r_crc      <= n_crc;
            r_seq      <= n_seq;
            r_pkts     <= n_pkts;
            r_bytes    <= n_bytes;
            r_open_len <= n_open_len;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte  <= sel_byte;
            r_out_last  <= last;
            r_out_eop   <= crc_lo;
            r_out_seq   <= n_seq;
            r_out_pkts  <= n_pkts;
            r_out_bytes <= n_bytes;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_out_byte           = r_out_byte;
    assign o_last_of_run        = r_out_last;
    assign o_end_of_packet      = r_out_eop;
    assign o_sequence_count     = r_out_seq;
    assign o_packets_sent_total = r_out_pkts;
    assign o_bytes_sent_total   = r_out_bytes;

endmodule
